// ===== src/tpfe_pkg.sv =====
// Shared constants, types and helper functions for the three point frame block.
// No dependencies; the top module, the CORDIC and the testbench import this package.
package tpfe_pkg;

   // Fixed datapath widths of the angle pipeline.
   localparam int NORM_BITS = 30;               // normalized magnitude lies in [2^29, 2^30)
   localparam int NW        = NORM_BITS + 2;    // signed width of a normalized value
   localparam int XW        = 35;               // CORDIC x/y register width
   localparam int AW        = 34;               // binary angle width, 2^32 units a turn

   localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic [AW-1:0]        SING_LIMIT   = 34'd1073058259;
   localparam logic [31:0]          INV_GAIN_Q32 = 32'd2608131496;

   // Millidegree conversion: units * 360000 / 2^32 = units * 5625 / 2^26.
   localparam int          MDEG_MUL_W = 13;
   localparam logic [12:0] MDEG_SCALE = 13'd5625;
   localparam int          MDEG_SHIFT = 26;
   localparam logic [17:0] LIMIT_AC   = 18'd180000;
   localparam logic [17:0] LIMIT_B    = 18'd90000;

   localparam logic [29:0] ATAN_TAB [32] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
      30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
   };

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_SINGULAR   = 2'd1,
      STATUS_DEGENERATE = 2'd2
   } status_type;

   // Binary angle to millidegrees, rounded with ties away from zero, saturated.
   function automatic logic signed [19:0] to_mdeg(input logic signed [AW-1:0] ang,
                                                  input logic [17:0] lim);
      logic [AW-1:0]            mag;
      logic [AW+MDEG_MUL_W-1:0] prod;
      logic [AW+MDEG_MUL_W-MDEG_SHIFT-1:0] r;
      logic [19:0]              r20;
      mag  = ang[AW-1] ? AW'(-ang) : AW'(ang);
      prod = (AW+MDEG_MUL_W)'(mag) * (AW+MDEG_MUL_W)'(MDEG_SCALE)
             + ((AW+MDEG_MUL_W)'(1) << (MDEG_SHIFT - 1));
      r    = prod[AW+MDEG_MUL_W-1:MDEG_SHIFT];
      if (r > (AW+MDEG_MUL_W-MDEG_SHIFT)'(lim)) begin
         r = (AW+MDEG_MUL_W-MDEG_SHIFT)'(lim);
      end
      r20 = 20'(r);
      return ang[AW-1] ? -$signed(r20) : $signed(r20);
   endfunction

endpackage

// ===== src/tpfe_req_if.sv =====
// Input channel of the three point frame block: three taught points per word.
// No dependencies.
interface tpfe_req_if #(parameter int COORD_WIDTH = 32);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] origin_x;
   logic signed [COORD_WIDTH-1:0] origin_y;
   logic signed [COORD_WIDTH-1:0] origin_z;
   logic signed [COORD_WIDTH-1:0] axis_point_x;
   logic signed [COORD_WIDTH-1:0] axis_point_y;
   logic signed [COORD_WIDTH-1:0] axis_point_z;
   logic signed [COORD_WIDTH-1:0] plane_point_x;
   logic signed [COORD_WIDTH-1:0] plane_point_y;
   logic signed [COORD_WIDTH-1:0] plane_point_z;

   modport source (output valid, origin_x, origin_y, origin_z, axis_point_x, axis_point_y,
                   axis_point_z, plane_point_x, plane_point_y, plane_point_z, input ready);
   modport sink (input valid, origin_x, origin_y, origin_z, axis_point_x, axis_point_y,
                 axis_point_z, plane_point_x, plane_point_y, plane_point_z, output ready);
endinterface

// ===== src/tpfe_rsp_if.sv =====
// Result channel of the three point frame block: frame origin, angles and status.
// No dependencies.
interface tpfe_rsp_if #(parameter int COORD_WIDTH = 32);
   logic valid;
   logic ready;
   logic signed [COORD_WIDTH-1:0] frame_x;
   logic signed [COORD_WIDTH-1:0] frame_y;
   logic signed [COORD_WIDTH-1:0] frame_z;
   logic signed [18:0] angle_a;
   logic signed [17:0] angle_b;
   logic signed [18:0] angle_c;
   logic [1:0] status;

   modport source (output valid, frame_x, frame_y, frame_z, angle_a, angle_b, angle_c,
                   status, input ready);
   modport sink (input valid, frame_x, frame_y, frame_z, angle_a, angle_b, angle_c,
                 status, output ready);
endinterface

// ===== src/three_point_frame_to_euler.sv =====
// Three point user frame to XYZ Euler angles, fully pipelined.
// Throughput is one word per cycle while the result channel is not stalled: every CORDIC iteration has its own stage.
// Reset clears only the valid bits of the stages; the payload needs none.
// Depends on tpfe_pkg, tpfe_req_if, tpfe_rsp_if and tpfe_cordic.
module three_point_frame_to_euler import tpfe_pkg::*; #(
   parameter int COORD_WIDTH  = 32,
   parameter int CORDIC_STEPS = 24
) (
   input logic     clock,
   input logic     reset,
   tpfe_req_if.sink   req_chan,
   tpfe_rsp_if.source rsp_chan
);

   // Widths of the exact front end. Differences gain one bit, the cross product
   // terms double that, and the difference of two terms adds one more.
   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;
   localparam int PW  = 2 * DW;
   localparam int ZW  = PW + 1;
   localparam int ZTW = $clog2(ZW + 1);
   // Gain removal product, and the C arguments built from the unscaled X axis.
   localparam int GPW = XW - 1 + 32;
   localparam int CVW = DW + XW;
   localparam int CTW = $clog2(CVW + 1);

   typedef struct packed {
      logic [2:0][CW-1:0] org;
      logic [2:0][DW-1:0] ax;
      logic [NW-1:0]      zn0;
      logic [NW-1:0]      zn1;
      logic [NW-1:0]      zn2;
      logic               zero;
   } side_a_type;

   typedef struct packed {
      logic [2:0][CW-1:0] org;
      logic [2:0][DW-1:0] ax;
      logic [NW-1:0]      zn1;
      logic [NW-1:0]      zn2;
      logic               zero;
      logic [AW-1:0]      a_ang;
   } side_b_type;

   typedef struct packed {
      logic [2:0][CW-1:0] org;
      logic               zero;
      logic               sing;
      logic [AW-1:0]      a_ang;
      logic [AW-1:0]      b_ang;
   } side_c_type;

   // Each stage holds a valid bit and advances when it is empty or its successor
   // moves, so bubbles close up and a stalled word is neither lost nor repeated.
   logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10, en11, en12, en13, en14;
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   logic s8_v_ff, s9_v_ff, s10_v_ff, s11_v_ff, s12_v_ff, s13_v_ff, s14_v_ff;
   logic ca_in_ready, cb_in_ready, cc_in_ready;
   logic ca_out_valid, cb_out_valid, cc_out_valid;

   assign en14 = !s14_v_ff || rsp_chan.ready;
   assign en13 = !s13_v_ff || cc_in_ready;
   assign en12 = !s12_v_ff || en13;
   assign en11 = !s11_v_ff || en12;
   assign en10 = !s10_v_ff || en11;
   assign en9  = !s9_v_ff  || en10;
   assign en8  = !s8_v_ff  || en9;
   assign en7  = !s7_v_ff  || cb_in_ready;
   assign en6  = !s6_v_ff  || ca_in_ready;
   assign en5  = !s5_v_ff  || en6;
   assign en4  = !s4_v_ff  || en5;
   assign en3  = !s3_v_ff  || en4;
   assign en2  = !s2_v_ff  || en3;
   assign en1  = !s1_v_ff  || en2;

   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         s6_v_ff  <= 1'b0;
         s7_v_ff  <= 1'b0;
         s8_v_ff  <= 1'b0;
         s9_v_ff  <= 1'b0;
         s10_v_ff <= 1'b0;
         s11_v_ff <= 1'b0;
         s12_v_ff <= 1'b0;
         s13_v_ff <= 1'b0;
         s14_v_ff <= 1'b0;
      end else begin
         if (en1)  s1_v_ff  <= req_chan.valid;
         if (en2)  s2_v_ff  <= s1_v_ff;
         if (en3)  s3_v_ff  <= s2_v_ff;
         if (en4)  s4_v_ff  <= s3_v_ff;
         if (en5)  s5_v_ff  <= s4_v_ff;
         if (en6)  s6_v_ff  <= s5_v_ff;
         if (en7)  s7_v_ff  <= ca_out_valid;
         if (en8)  s8_v_ff  <= cb_out_valid;
         if (en9)  s9_v_ff  <= s8_v_ff;
         if (en10) s10_v_ff <= s9_v_ff;
         if (en11) s11_v_ff <= s10_v_ff;
         if (en12) s12_v_ff <= s11_v_ff;
         if (en13) s13_v_ff <= s12_v_ff;
         if (en14) s14_v_ff <= cc_out_valid;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: the X axis and the in-plane vector relative to the origin.
   // ---------------------------------------------------------------------
   logic [CW-1:0]        s1_org_ff [3];
   logic signed [DW-1:0] s1_ax_ff  [3];
   logic signed [DW-1:0] s1_pl_ff  [3];

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_org_ff[0] <= req_chan.origin_x;
         s1_org_ff[1] <= req_chan.origin_y;
         s1_org_ff[2] <= req_chan.origin_z;
         s1_ax_ff[0]  <= DW'(req_chan.axis_point_x) - DW'(req_chan.origin_x);
         s1_ax_ff[1]  <= DW'(req_chan.axis_point_y) - DW'(req_chan.origin_y);
         s1_ax_ff[2]  <= DW'(req_chan.axis_point_z) - DW'(req_chan.origin_z);
         s1_pl_ff[0]  <= DW'(req_chan.plane_point_x) - DW'(req_chan.origin_x);
         s1_pl_ff[1]  <= DW'(req_chan.plane_point_y) - DW'(req_chan.origin_y);
         s1_pl_ff[2]  <= DW'(req_chan.plane_point_z) - DW'(req_chan.origin_z);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: the six products of the cross product Z = X x V.
   // ---------------------------------------------------------------------
   logic [CW-1:0]        s2_org_ff [3];
   logic signed [DW-1:0] s2_ax_ff  [3];
   logic signed [PW-1:0] s2_p_ff   [6];

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_org_ff  <= s1_org_ff;
         s2_ax_ff   <= s1_ax_ff;
         s2_p_ff[0] <= PW'(s1_ax_ff[1]) * PW'(s1_pl_ff[2]);
         s2_p_ff[1] <= PW'(s1_ax_ff[2]) * PW'(s1_pl_ff[1]);
         s2_p_ff[2] <= PW'(s1_ax_ff[2]) * PW'(s1_pl_ff[0]);
         s2_p_ff[3] <= PW'(s1_ax_ff[0]) * PW'(s1_pl_ff[2]);
         s2_p_ff[4] <= PW'(s1_ax_ff[0]) * PW'(s1_pl_ff[1]);
         s2_p_ff[5] <= PW'(s1_ax_ff[1]) * PW'(s1_pl_ff[0]);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: exact Z.
   // ---------------------------------------------------------------------
   logic [CW-1:0]        s3_org_ff [3];
   logic signed [DW-1:0] s3_ax_ff  [3];
   logic signed [ZW-1:0] s3_z_ff   [3];

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_org_ff  <= s2_org_ff;
         s3_ax_ff   <= s2_ax_ff;
         s3_z_ff[0] <= ZW'(s2_p_ff[0]) - ZW'(s2_p_ff[1]);
         s3_z_ff[1] <= ZW'(s2_p_ff[2]) - ZW'(s2_p_ff[3]);
         s3_z_ff[2] <= ZW'(s2_p_ff[4]) - ZW'(s2_p_ff[5]);
      end
   end

   // ---------------------------------------------------------------------
   // Stages 4 to 6: Z is scaled by one common power of two. The OR of the
   // magnitudes has the same top bit as the largest of them. A zero Z means
   // coincident or collinear points.
   // ---------------------------------------------------------------------
   logic [CW-1:0]        s4_org_ff [3];
   logic signed [DW-1:0] s4_ax_ff  [3];
   logic [ZW-1:0]        s4_mag_ff [3];
   logic [2:0]           s4_neg_ff;
   logic [ZW-1:0]        s4_or_ff;
   logic [ZW-1:0]        z_mag_in [3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         z_mag_in[j] = s3_z_ff[j][ZW-1] ? ZW'(-s3_z_ff[j]) : ZW'(s3_z_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_org_ff <= s3_org_ff;
         s4_ax_ff  <= s3_ax_ff;
         s4_mag_ff <= z_mag_in;
         s4_neg_ff <= {s3_z_ff[2][ZW-1], s3_z_ff[1][ZW-1], s3_z_ff[0][ZW-1]};
         s4_or_ff  <= z_mag_in[0] | z_mag_in[1] | z_mag_in[2];
      end
   end

   logic [CW-1:0]        s5_org_ff [3];
   logic signed [DW-1:0] s5_ax_ff  [3];
   logic [ZW-1:0]        s5_mag_ff [3];
   logic [2:0]           s5_neg_ff;
   logic                 s5_zero_ff;
   logic [ZTW-1:0]       s5_top_ff;
   logic [ZTW-1:0]       z_top_in;

   always_comb begin
      z_top_in = '0;
      for (int b = 0; b < ZW; b++) begin
         if (s4_or_ff[b]) begin
            z_top_in = ZTW'(b + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_org_ff  <= s4_org_ff;
         s5_ax_ff   <= s4_ax_ff;
         s5_mag_ff  <= s4_mag_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_zero_ff <= (s4_or_ff == '0);
         s5_top_ff  <= z_top_in;
      end
   end

   // Shifting left by NORM_BITS and then right by the bit count covers both
   // directions of the scaling with one shifter; a right scale truncates.
   side_a_type           s6_side_ff;
   logic signed [NW-1:0] s6_zn_ff [3];
   logic signed [NW-1:0] zn_in [3];

   always_comb begin
      logic [ZW+NORM_BITS-1:0] ext;
      logic [NW-1:0]           m;
      for (int j = 0; j < 3; j++) begin
         ext      = {s5_mag_ff[j], {NORM_BITS{1'b0}}} >> s5_top_ff;
         m        = NW'(ext[NORM_BITS-1:0]);
         zn_in[j] = s5_neg_ff[j] ? -$signed(m) : $signed(m);
      end
   end

   always_ff @(posedge clock) begin
      if (en6) begin
         for (int j = 0; j < 3; j++) begin
            s6_side_ff.org[j] <= s5_org_ff[j];
            s6_side_ff.ax[j]  <= s5_ax_ff[j];
         end
         s6_side_ff.zn0  <= zn_in[0];
         s6_side_ff.zn1  <= zn_in[1];
         s6_side_ff.zn2  <= zn_in[2];
         s6_side_ff.zero <= s5_zero_ff;
         s6_zn_ff        <= zn_in;
      end
   end

   // ---------------------------------------------------------------------
   // CORDIC A: atan2(-Z1, Z2). Its final x is K*hypot(Z1, Z2).
   // ---------------------------------------------------------------------
   logic signed [AW-1:0] ca_ang;
   logic signed [XW-1:0] ca_len;
   logic [$bits(side_a_type)-1:0] ca_side;
   side_a_type ca_side_s;

   tpfe_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W($bits(side_a_type))) u_cordic_a (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s6_v_ff),
      .in_ready (ca_in_ready),
      .in_x     (XW'(s6_zn_ff[2])),
      .in_y     (XW'(-s6_zn_ff[1])),
      .in_side  (s6_side_ff),
      .out_valid(ca_out_valid),
      .out_ready(en7),
      .out_ang  (ca_ang),
      .out_len  (ca_len),
      .out_side (ca_side)
   );

   assign ca_side_s = side_a_type'(ca_side);

   // Stage 7: divide the CORDIC gain out of the length by a Q32 reciprocal.
   side_b_type           s7_side_ff;
   logic [XW-2:0]        s7_hyp_ff;
   logic signed [NW-1:0] s7_zn0_ff;
   logic [GPW-1:0]       g1_prod;

   assign g1_prod = GPW'(ca_len[XW-2:0]) * GPW'(INV_GAIN_Q32);

   always_ff @(posedge clock) begin
      if (en7) begin
         s7_side_ff.org   <= ca_side_s.org;
         s7_side_ff.ax    <= ca_side_s.ax;
         s7_side_ff.zn1   <= ca_side_s.zn1;
         s7_side_ff.zn2   <= ca_side_s.zn2;
         s7_side_ff.zero  <= ca_side_s.zero;
         s7_side_ff.a_ang <= ca_ang;
         s7_hyp_ff        <= g1_prod[GPW-1:32];
         s7_zn0_ff        <= $signed(ca_side_s.zn0);
      end
   end

   // ---------------------------------------------------------------------
   // CORDIC B: atan2(Z0, hypot(Z1, Z2)). Its final x is K*|Z|.
   // ---------------------------------------------------------------------
   logic signed [AW-1:0] cb_ang;
   logic signed [XW-1:0] cb_len;
   logic [$bits(side_b_type)-1:0] cb_side;
   side_b_type cb_side_s;

   tpfe_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W($bits(side_b_type))) u_cordic_b (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s7_v_ff),
      .in_ready (cb_in_ready),
      .in_x     ($signed({1'b0, s7_hyp_ff})),
      .in_y     (XW'(s7_zn0_ff)),
      .in_side  (s7_side_ff),
      .out_valid(cb_out_valid),
      .out_ready(en8),
      .out_ang  (cb_ang),
      .out_len  (cb_len),
      .out_side (cb_side)
   );

   assign cb_side_s = side_b_type'(cb_side);

   // Stage 8: |Z| without the gain, and the gimbal check on B, which is
   // singular within a thousandth of a radian of a quarter turn.
   side_c_type           s8_side_ff;
   logic signed [DW-1:0] s8_ax_ff [3];
   logic signed [NW-1:0] s8_zn1_ff, s8_zn2_ff;
   logic [XW-2:0]        s8_zmag_ff;
   logic [GPW-1:0]       g2_prod;
   logic [AW-1:0]        b_mag;

   assign g2_prod = GPW'(cb_len[XW-2:0]) * GPW'(INV_GAIN_Q32);
   assign b_mag   = cb_ang[AW-1] ? AW'(-cb_ang) : AW'(cb_ang);

   always_ff @(posedge clock) begin
      if (en8) begin
         s8_side_ff.org   <= cb_side_s.org;
         s8_side_ff.zero  <= cb_side_s.zero;
         s8_side_ff.sing  <= (b_mag >= SING_LIMIT);
         s8_side_ff.a_ang <= cb_side_s.a_ang;
         s8_side_ff.b_ang <= cb_ang;
         for (int j = 0; j < 3; j++) begin
            s8_ax_ff[j] <= $signed(cb_side_s.ax[j]);
         end
         s8_zn1_ff  <= $signed(cb_side_s.zn1);
         s8_zn2_ff  <= $signed(cb_side_s.zn2);
         s8_zmag_ff <= g2_prod[GPW-1:32];
      end
   end

   // ---------------------------------------------------------------------
   // Stages 9 to 13: arguments of C. With Y = Z x X, atan2(-Y0/|Y|, X0/|X|)
   // equals atan2(Z2*X1 - Z1*X2, X0*|Z|), which needs no square root. Both
   // arguments are then scaled together like Z above.
   // ---------------------------------------------------------------------
   side_c_type            s9_side_ff;
   logic signed [CVW-1:0] s9_cw0_ff, s9_q1_ff, s9_q2_ff;

   always_ff @(posedge clock) begin
      if (en9) begin
         s9_side_ff <= s8_side_ff;
         s9_cw0_ff  <= CVW'(s8_ax_ff[0]) * CVW'($signed({1'b0, s8_zmag_ff}));
         s9_q1_ff   <= CVW'(s8_zn2_ff) * CVW'(s8_ax_ff[1]);
         s9_q2_ff   <= CVW'(s8_zn1_ff) * CVW'(s8_ax_ff[2]);
      end
   end

   side_c_type            s10_side_ff;
   logic signed [CVW-1:0] s10_cw_ff [2];

   always_ff @(posedge clock) begin
      if (en10) begin
         s10_side_ff  <= s9_side_ff;
         s10_cw_ff[0] <= s9_cw0_ff;
         s10_cw_ff[1] <= s9_q1_ff - s9_q2_ff;
      end
   end

   side_c_type     s11_side_ff;
   logic [CVW-1:0] s11_mag_ff [2];
   logic [1:0]     s11_neg_ff;
   logic [CVW-1:0] s11_or_ff;
   logic [CVW-1:0] c_mag_in [2];

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         c_mag_in[j] = s10_cw_ff[j][CVW-1] ? CVW'(-s10_cw_ff[j]) : CVW'(s10_cw_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en11) begin
         s11_side_ff <= s10_side_ff;
         s11_mag_ff  <= c_mag_in;
         s11_neg_ff  <= {s10_cw_ff[1][CVW-1], s10_cw_ff[0][CVW-1]};
         s11_or_ff   <= c_mag_in[0] | c_mag_in[1];
      end
   end

   side_c_type     s12_side_ff;
   logic [CVW-1:0] s12_mag_ff [2];
   logic [1:0]     s12_neg_ff;
   logic [CTW-1:0] s12_top_ff;
   logic [CTW-1:0] c_top_in;

   always_comb begin
      c_top_in = '0;
      for (int b = 0; b < CVW; b++) begin
         if (s11_or_ff[b]) begin
            c_top_in = CTW'(b + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en12) begin
         s12_side_ff <= s11_side_ff;
         s12_mag_ff  <= s11_mag_ff;
         s12_neg_ff  <= s11_neg_ff;
         s12_top_ff  <= c_top_in;
      end
   end

   side_c_type           s13_side_ff;
   logic signed [NW-1:0] s13_cv_ff [2];
   logic signed [NW-1:0] cv_in [2];

   always_comb begin
      logic [CVW+NORM_BITS-1:0] ext;
      logic [NW-1:0]            m;
      for (int j = 0; j < 2; j++) begin
         ext      = {s12_mag_ff[j], {NORM_BITS{1'b0}}} >> s12_top_ff;
         m        = NW'(ext[NORM_BITS-1:0]);
         cv_in[j] = s12_neg_ff[j] ? -$signed(m) : $signed(m);
      end
   end

   always_ff @(posedge clock) begin
      if (en13) begin
         s13_side_ff <= s12_side_ff;
         s13_cv_ff   <= cv_in;
      end
   end

   // ---------------------------------------------------------------------
   // CORDIC C: atan2 of the scaled C arguments; its length is not needed.
   // ---------------------------------------------------------------------
   logic signed [AW-1:0] cc_ang;
   logic signed [XW-1:0] cc_len;
   logic [$bits(side_c_type)-1:0] cc_side;
   side_c_type cc_side_s;

   tpfe_cordic #(.STEPS(CORDIC_STEPS), .SIDE_W($bits(side_c_type))) u_cordic_c (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s13_v_ff),
      .in_ready (cc_in_ready),
      .in_x     (XW'(s13_cv_ff[0])),
      .in_y     (XW'(s13_cv_ff[1])),
      .in_side  (s13_side_ff),
      .out_valid(cc_out_valid),
      .out_ready(en14),
      .out_ang  (cc_ang),
      .out_len  (cc_len),
      .out_side (cc_side)
   );

   assign cc_side_s = side_c_type'(cc_side);

   // ---------------------------------------------------------------------
   // Stage 14, the output register: millidegrees and status. A degenerate
   // point set outranks the gimbal check, and either one zeroes the word.
   // ---------------------------------------------------------------------
   status_type           status_in;
   logic signed [19:0]   a_md, b_md, c_md;
   logic                 len_sign_unused;

   assign a_md = to_mdeg(cc_side_s.a_ang, LIMIT_AC);
   assign b_md = to_mdeg(cc_side_s.b_ang, LIMIT_B);
   assign c_md = to_mdeg(cc_ang, LIMIT_AC);
   // The final length of C is not used; only its sign bit is tied off here.
   assign len_sign_unused = cc_len[XW-1];

   always_comb begin
      if (cc_side_s.zero) begin
         status_in = STATUS_DEGENERATE;
      end else if (cc_side_s.sing) begin
         status_in = STATUS_SINGULAR;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en14) begin
         rsp_chan.status <= status_in;
         if (status_in == STATUS_OK) begin
            rsp_chan.frame_x <= cc_side_s.org[0];
            rsp_chan.frame_y <= cc_side_s.org[1];
            rsp_chan.frame_z <= cc_side_s.org[2];
            rsp_chan.angle_a <= a_md[18:0];
            rsp_chan.angle_b <= b_md[17:0];
            rsp_chan.angle_c <= c_md[18:0];
         end else begin
            rsp_chan.frame_x <= '0;
            rsp_chan.frame_y <= '0;
            rsp_chan.frame_z <= '0;
            rsp_chan.angle_a <= '0;
            rsp_chan.angle_b <= '0;
            rsp_chan.angle_c <= '0;
         end
      end
   end

   assign rsp_chan.valid = s14_v_ff && !len_sign_unused | s14_v_ff;

endmodule

// ===== src/tpfe_cordic.sv =====
// Fully pipelined vectoring CORDIC for atan2 with a sideband that travels along.
// Depends on tpfe_pkg for widths, the arctangent table and the quarter turn.
module tpfe_cordic import tpfe_pkg::*; #(
   parameter int STEPS  = 24,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [XW-1:0]     in_x,
   input  logic signed [XW-1:0]     in_y,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [AW-1:0]     out_ang,
   output logic signed [XW-1:0]     out_len,
   output logic [SIDE_W-1:0]        out_side
);

   logic                  valid_ff [STEPS+1];
   logic signed [XW-1:0]  x_ff     [STEPS+1];
   logic signed [XW-1:0]  y_ff     [STEPS+1];
   logic signed [AW-1:0]  ang_ff   [STEPS+1];
   logic                  zero_ff  [STEPS+1];
   logic [SIDE_W-1:0]     side_ff  [STEPS+1];
   logic [STEPS+1:0]      en;

   assign en[STEPS+1] = out_ready;
   assign in_ready    = en[0];

   // Stage 0: a quarter turn brings a vector with negative x into the right half plane.
   logic signed [XW-1:0] x0_in, y0_in;
   logic signed [AW-1:0] ang0_in;
   always_comb begin
      x0_in   = in_x;
      y0_in   = in_y;
      ang0_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x0_in   = in_y;
            y0_in   = -in_x;
            ang0_in = QUARTER_TURN;
         end else begin
            x0_in   = -in_y;
            y0_in   = in_x;
            ang0_in = -QUARTER_TURN;
         end
      end
   end

   assign en[0] = !valid_ff[0] || en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en[0]) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         ang_ff[0]  <= ang0_in;
         zero_ff[0] <= (in_x == 0) && (in_y == 0);
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      logic signed [XW-1:0] x_in, y_in;
      logic signed [AW-1:0] ang_in;

      assign en[k] = !valid_ff[k] || en[k+1];

      always_comb begin
         if (y_ff[k-1] >= 0) begin
            x_in   = x_ff[k-1] + (y_ff[k-1] >>> (k - 1));
            y_in   = y_ff[k-1] - (x_ff[k-1] >>> (k - 1));
            ang_in = ang_ff[k-1] + AW'(ATAN_TAB[k-1]);
         end else begin
            x_in   = x_ff[k-1] - (y_ff[k-1] >>> (k - 1));
            y_in   = y_ff[k-1] + (x_ff[k-1] >>> (k - 1));
            ang_in = ang_ff[k-1] - AW'(ATAN_TAB[k-1]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en[k]) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            x_ff[k]    <= x_in;
            y_ff[k]    <= y_in;
            ang_ff[k]  <= ang_in;
            zero_ff[k] <= zero_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_ang   = zero_ff[STEPS] ? '0 : ang_ff[STEPS];
   assign out_len   = x_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

// ===== test/three_point_frame_to_euler_tb.sv =====
// Testbench for three_point_frame_to_euler: random and directed point triples, checked
// against a bit-exact predictor of the fixed-point frame and CORDIC datapath.
// Depends on tpfe_pkg, tpfe_req_if, tpfe_rsp_if and the block itself.
`timescale 1ns / 1ps

module three_point_frame_to_euler_tb import tpfe_pkg::*;;

   localparam int CW = 32;
   localparam int DRAIN_CYCLES = 200;   // leaves margin over the pipeline latency
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [127:0] wide_type;
   typedef logic signed [63:0] word_type;

   typedef struct packed {
      coord_type ox, oy, oz, ax, ay, az, px, py, pz;
   } points_type;

   typedef struct packed {
      coord_type fx, fy, fz;
      logic signed [18:0] a;
      logic signed [17:0] b;
      logic signed [18:0] c;
      status_type st;
   } frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpfe_req_if #(.COORD_WIDTH(CW)) req_if ();
   tpfe_rsp_if #(.COORD_WIDTH(CW)) rsp_if ();

   three_point_frame_to_euler #(.COORD_WIDTH(CW), .CORDIC_STEPS(24)) u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source)
   );

   always #6 clock = ~clock;

   points_type pending_points[$];
   frame_type expected_frames[$];
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int failures = 0;
   int quiet_cycles = 0;

   // Number of significant bits of a magnitude.
   function automatic int bit_count(input wide_type m);
      int n;
      n = 0;
      for (int i = 0; i < 128; i++) begin
         if (m[i]) begin
            n = i + 1;
         end
      end
      return n;
   endfunction

   function automatic wide_type wide_abs(input wide_type v);
      return v < 0 ? -v : v;
   endfunction

   // Scales a group by one power of two so its largest magnitude lands in [2^29, 2^30).
   function automatic void scale_group(input wide_type v[3], input int n,
                                       output word_type o[3]);
      int top;
      wide_type m;
      top = 0;
      for (int i = 0; i < n; i++) begin
         if (bit_count(wide_abs(v[i])) > top) begin
            top = bit_count(wide_abs(v[i]));
         end
      end
      for (int i = 0; i < 3; i++) begin
         o[i] = 0;
      end
      for (int i = 0; i < n; i++) begin
         m = wide_abs(v[i]);
         if (top > 30) begin
            m = m >> (top - 30);
         end else begin
            m = m << (30 - top);
         end
         o[i] = v[i] < 0 ? -word_type'(m) : word_type'(m);
      end
   endfunction

   // Vectoring CORDIC atan2(y, x) in binary units; len gets the gain-scaled length.
   function automatic word_type vector_angle(input word_type x_in, input word_type y_in,
                                             output word_type len);
      word_type x, y, ang, t, dx, dy;
      x = x_in;
      y = y_in;
      ang = 0;
      if (x == 0 && y == 0) begin
         len = 0;
         return 0;
      end
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            ang = QUARTER_TURN;
         end else begin
            x = -y;
            y = t;
            ang = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            ang = ang + word_type'(ATAN_TAB[i]);
         end else begin
            x = x - dx;
            y = y + dy;
            ang = ang - word_type'(ATAN_TAB[i]);
         end
      end
      len = x;
      return ang;
   endfunction

   function automatic word_type strip_gain(input word_type len);
      logic [95:0] p;
      p = 96'(len) * 96'(INV_GAIN_Q32);
      return word_type'(p >> 32);
   endfunction

   function automatic word_type millideg(input word_type ang, input word_type lim);
      logic [63:0] mag, r;
      mag = ang < 0 ? 64'(-ang) : 64'(ang);
      r = (mag * 64'd5625 + (64'd1 << 25)) >> 26;
      if (r > 64'(lim)) begin
         r = 64'(lim);
      end
      return ang < 0 ? -word_type'(r) : word_type'(r);
   endfunction

   // Expected frame of one point triple.
   function automatic frame_type frame_of(input points_type p);
      frame_type f;
      word_type xv[3], vv[3], zn[3], cv[3], len1, len2, len3, a_ang, b_ang, c_ang;
      wide_type zc[3], cw[3];
      xv[0] = word_type'(p.ax) - word_type'(p.ox);
      xv[1] = word_type'(p.ay) - word_type'(p.oy);
      xv[2] = word_type'(p.az) - word_type'(p.oz);
      vv[0] = word_type'(p.px) - word_type'(p.ox);
      vv[1] = word_type'(p.py) - word_type'(p.oy);
      vv[2] = word_type'(p.pz) - word_type'(p.oz);
      zc[0] = wide_type'(xv[1]) * wide_type'(vv[2]) - wide_type'(xv[2]) * wide_type'(vv[1]);
      zc[1] = wide_type'(xv[2]) * wide_type'(vv[0]) - wide_type'(xv[0]) * wide_type'(vv[2]);
      zc[2] = wide_type'(xv[0]) * wide_type'(vv[1]) - wide_type'(xv[1]) * wide_type'(vv[0]);
      f = '0;
      if (zc[0] == 0 && zc[1] == 0 && zc[2] == 0) begin
         f.st = STATUS_DEGENERATE;
         return f;
      end
      scale_group(zc, 3, zn);
      a_ang = vector_angle(zn[2], -zn[1], len1);
      b_ang = vector_angle(strip_gain(len1), zn[0], len2);
      if ((b_ang < 0 ? -b_ang : b_ang) >= word_type'(SING_LIMIT)) begin
         f.st = STATUS_SINGULAR;
         return f;
      end
      cw[0] = wide_type'(xv[0]) * wide_type'(strip_gain(len2));
      cw[1] = wide_type'(zn[2]) * wide_type'(xv[1]) - wide_type'(zn[1]) * wide_type'(xv[2]);
      cw[2] = 0;
      scale_group(cw, 2, cv);
      c_ang = vector_angle(cv[0], cv[1], len3);
      f.fx = p.ox;
      f.fy = p.oy;
      f.fz = p.oz;
      f.a = 19'(millideg(a_ang, 180000));
      f.b = 18'(millideg(b_ang, 90000));
      f.c = 19'(millideg(c_ang, 180000));
      f.st = STATUS_OK;
      return f;
   endfunction

   function automatic coord_type near_coord(input int span);
      return coord_type'($urandom_range(0, 2 * span)) - coord_type'(span);
   endfunction

   // Random point triple; most are well-formed frames, some hit the special cases.
   function automatic points_type random_points();
      points_type p;
      int kind;
      int k;
      kind = $urandom_range(0, 9);
      p = {$urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom};
      case (kind)
         0, 1: begin
            // Full-range coordinates.
         end
         2, 3, 4, 5: begin
            // A realistic cell of about a metre around a random origin.
            p.ox = near_coord(1000000);
            p.oy = near_coord(1000000);
            p.oz = near_coord(1000000);
            p.ax = p.ox + near_coord(500000);
            p.ay = p.oy + near_coord(500000);
            p.az = p.oz + near_coord(500000);
            p.px = p.ox + near_coord(500000);
            p.py = p.oy + near_coord(500000);
            p.pz = p.oz + near_coord(500000);
         end
         6: begin
            // Frame normal close to the X axis, near the gimbal singularity.
            p.ax = p.ox + near_coord(40);
            p.ay = p.oy + 100000 + near_coord(1000);
            p.az = p.oz + near_coord(40);
            p.px = p.ox + near_coord(40);
            p.py = p.oy + near_coord(40);
            p.pz = p.oz + 100000 + near_coord(1000);
         end
         7: begin
            // Collinear points.
            k = $urandom_range(0, 6) - 3;
            p.ox = near_coord(100000);
            p.oy = near_coord(100000);
            p.oz = near_coord(100000);
            p.ax = p.ox + near_coord(10000);
            p.ay = p.oy + near_coord(10000);
            p.az = p.oz + near_coord(10000);
            p.px = p.ox + k * (p.ax - p.ox);
            p.py = p.oy + k * (p.ay - p.oy);
            p.pz = p.oz + k * (p.az - p.oz);
         end
         8: begin
            // Small offsets, so axis-aligned and opposite cases come up often.
            p.ax = p.ox + near_coord(2);
            p.ay = p.oy + near_coord(2);
            p.az = p.oz + near_coord(2);
            p.px = p.ox + near_coord(2);
            p.py = p.oy + near_coord(2);
            p.pz = p.oz + near_coord(2);
         end
         default: begin
            // Coincident points.
            p.ax = p.ox;
            p.ay = p.oy;
            p.az = p.oz;
         end
      endcase
      return p;
   endfunction

   function automatic points_type frame_points(input coord_type o0, input coord_type o1,
                                               input coord_type o2, input coord_type x0,
                                               input coord_type x1, input coord_type x2,
                                               input coord_type v0, input coord_type v1,
                                               input coord_type v2);
      points_type p;
      p = {o0, o1, o2, o0 + x0, o1 + x1, o2 + x2, o0 + v0, o1 + v1, o2 + v2};
      return p;
   endfunction

   // Sender: offers the next pending word, holding it until the block takes it.
   always @(posedge clock) begin
      points_type p;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending_points.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            p = pending_points.pop_front();
            req_if.origin_x <= p.ox;
            req_if.origin_y <= p.oy;
            req_if.origin_z <= p.oz;
            req_if.axis_point_x <= p.ax;
            req_if.axis_point_y <= p.ay;
            req_if.axis_point_z <= p.az;
            req_if.plane_point_x <= p.px;
            req_if.plane_point_y <= p.py;
            req_if.plane_point_z <= p.pz;
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_served < hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= $urandom_range(0, 99) >= stall_pct;
      end
   end

   // Monitor: predicts each accepted word and checks each accepted result.
   always @(posedge clock) begin
      points_type p;
      frame_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            p = {req_if.origin_x, req_if.origin_y, req_if.origin_z,
                 req_if.axis_point_x, req_if.axis_point_y, req_if.axis_point_z,
                 req_if.plane_point_x, req_if.plane_point_y, req_if.plane_point_z};
            expected_frames.push_back(frame_of(p));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_frames.size() == 0) begin
               $error("result word with no expectation waiting");
               failures++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_if.frame_x !== want.fx) begin
                  $error("frame_x expected %0d actual %0d", want.fx, rsp_if.frame_x);
                  failures++;
               end
               if (rsp_if.frame_y !== want.fy) begin
                  $error("frame_y expected %0d actual %0d", want.fy, rsp_if.frame_y);
                  failures++;
               end
               if (rsp_if.frame_z !== want.fz) begin
                  $error("frame_z expected %0d actual %0d", want.fz, rsp_if.frame_z);
                  failures++;
               end
               if (rsp_if.angle_a !== want.a) begin
                  $error("angle_a expected %0d actual %0d", want.a, rsp_if.angle_a);
                  failures++;
               end
               if (rsp_if.angle_b !== want.b) begin
                  $error("angle_b expected %0d actual %0d", want.b, rsp_if.angle_b);
                  failures++;
               end
               if (rsp_if.angle_c !== want.c) begin
                  $error("angle_c expected %0d actual %0d", want.c, rsp_if.angle_c);
                  failures++;
               end
               if (rsp_if.status !== want.st) begin
                  $error("status expected %0d actual %0d", want.st, rsp_if.status);
                  failures++;
               end
            end
         end
         // The watchdog only runs while something is still owed by either side.
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (pending_points.size() == 0 && expected_frames.size() == 0 &&
              !req_if.valid)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic drain();
      while (pending_points.size() > 0 || expected_frames.size() > 0 || req_if.valid) begin
         @(posedge clock);
      end
   endtask

   initial begin
      coord_type hi, lo;
      hi = 32'sh7fffffff;
      lo = 32'sh80000000;
      req_if.valid = 1'b0;
      req_if.origin_x = '0;
      req_if.origin_y = '0;
      req_if.origin_z = '0;
      req_if.axis_point_x = '0;
      req_if.axis_point_y = '0;
      req_if.axis_point_z = '0;
      req_if.plane_point_x = '0;
      req_if.plane_point_y = '0;
      req_if.plane_point_z = '0;
      rsp_if.ready = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words: identity frame, rotated frames, special cases and extremes.
      pending_points.push_back(frame_points(0, 0, 0, 1000, 0, 0, 0, 1000, 0));
      pending_points.push_back(frame_points(5, -7, 9, 0, 1000, 0, -1000, 0, 0));
      pending_points.push_back(frame_points(0, 0, 0, 1000, 0, 0, 0, 0, 1000));
      pending_points.push_back(frame_points(0, 0, 0, 1000, 0, 0, 0, 0, -1000));
      // Normal opposite to +Z: A lands exactly on the half turn.
      pending_points.push_back(frame_points(0, 0, 0, 1000, 0, 0, 0, -1000, 0));
      // Normal along +X and -X: gimbal singular.
      pending_points.push_back(frame_points(0, 0, 0, 0, 1000, 0, 0, 0, 1000));
      pending_points.push_back(frame_points(0, 0, 0, 0, 0, 1000, 0, 1000, 0));
      // Just outside the singular band.
      pending_points.push_back(frame_points(0, 0, 0, 0, 1000000, 0, 1100, 0, 1000000));
      // X axis pointing backward, so C is near the half turn.
      pending_points.push_back(frame_points(0, 0, 0, -1000, 0, 0, 0, -1000, 0));
      pending_points.push_back(frame_points(0, 0, 0, -1000, 1, 0, 0, -1000, 0));
      // Coincident, all zero and collinear points.
      pending_points.push_back(frame_points(0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_points.push_back(frame_points(hi, lo, hi, 0, 0, 0, 0, 0, 0));
      pending_points.push_back(frame_points(1, 2, 3, 10, 20, 30, -30, -60, -90));
      // Extremes of every coordinate field.
      pending_points.push_back({lo, lo, lo, hi, hi, hi, hi, lo, hi});
      pending_points.push_back({hi, hi, hi, lo, lo, lo, lo, hi, lo});
      pending_points.push_back({lo, hi, lo, hi, lo, lo, lo, lo, hi});
      pending_points.push_back({hi, lo, hi, lo, hi, hi, hi, hi, lo});
      pending_points.push_back({lo, lo, lo, hi, lo, lo, lo, hi, lo});
      pending_points.push_back(frame_points(0, 0, 0, hi, 0, 0, 0, hi, 0));
      pending_points.push_back(frame_points(0, 0, 0, -1, -1, 0, 1, -1, 0));
      drain();

      // Random phases: no idling, idle sender, stalling receiver, both.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 49 : (phase == 3) ? 24 : 0;
         stall_pct = (phase == 2) ? 49 : (phase == 3) ? 24 : 0;
         for (int i = 0; i < 160; i++) begin
            pending_points.push_back(random_points());
         end
         // While the sender keeps offering, a long hold-off backs the pipeline up.
         if (phase == 0) begin
            hold_requests = hold_requests + 1;
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_frames.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
